// ----- rtl/bmfe_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bmfe_pkg
// Shared constants and types for the bus message field extractor.
// ---------------------------------------------------------------------------
package bmfe_pkg;

	localparam int MAX_WORDS_DEFAULT = 32;

	localparam int TERM_W   = 5;
	localparam int SUBADR_W = 5;
	localparam int WORD_W   = 16;
	localparam int IDX_W    = 6;
	localparam int BITPOS_W = 4;
	localparam int SCALE_W  = 32;
	localparam int VALUE_W  = 64;
	localparam int STAMP_W  = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	// IEEE-754 single: exponent of all ones is NaN or infinity, bias plus
	// mantissa width is the exponent at which the integer mantissa is exact.
	localparam logic [7:0] FLT_EXP_SPECIAL = 8'hFF;
	localparam int         FLT_EXP_UNIT    = 150;

	typedef enum logic [1:0] {
		MODE_BIT      = 2'd0,
		MODE_UNSIGNED = 2'd1,
		MODE_SIGNED   = 2'd2,
		MODE_FLOAT    = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TERMINAL   = 3'd0,
		REG_SUBADDRESS = 3'd1,
		REG_DIRECTION  = 3'd2,
		REG_FIRST_WORD = 3'd3,
		REG_FINAL_WORD = 3'd4,
		REG_MODE       = 3'd5,
		REG_BIT_POS    = 3'd6,
		REG_SCALE      = 3'd7
	} reg_idx_t;

endpackage
`default_nettype wire

// ----- rtl/bus_message_field_extractor.sv -----
`default_nettype none
// A field reaches out_valid through the stage registers and the output register
// once the closing word of a matching message is accepted; other words give no result.
// Throughput: one data word per cycle while in_stall is low. The 64 x 32 scale product
// is split into two 32 x 32 partial products, which sets the depth of the result pipeline.
// Reset: control state and word tracking clear, configuration returns to
// terminal 0, subaddress 0, receive, words 1..1, unsigned, bit 0, scale 1.0.
// ---------------------------------------------------------------------------
// bus_message_field_extractor
// Tracks the data words of each bus message and emits one configured field,
// decoded and scaled to saturated Q48.16, when the message closes.
// ---------------------------------------------------------------------------
module bus_message_field_extractor #(
	parameter int MAX_WORDS = bmfe_pkg::MAX_WORDS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              cfg_write,
	input  wire logic [bmfe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bmfe_pkg::CFG_DATA_W-1:0]   cfg_data,

	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [bmfe_pkg::TERM_W-1:0]       terminal,
	input  wire logic [bmfe_pkg::SUBADR_W-1:0]     subaddress,
	input  wire logic                              direction,
	input  wire logic [bmfe_pkg::WORD_W-1:0]       data_word,
	input  wire logic                              last_word,
	input  wire logic [bmfe_pkg::STAMP_W-1:0]      time_stamp,

	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [bmfe_pkg::VALUE_W-1:0]    field_value,
	output logic [bmfe_pkg::STAMP_W-1:0]           value_time,
	output logic                                   saturated
);

	localparam logic [bmfe_pkg::IDX_W-1:0] MaxCount = bmfe_pkg::IDX_W'(MAX_WORDS);

	// Configuration registers
	logic [bmfe_pkg::TERM_W-1:0]   match_terminal_q;
	logic [bmfe_pkg::SUBADR_W-1:0] match_subaddress_q;
	logic                          match_direction_q;
	logic [bmfe_pkg::IDX_W-1:0]    first_word_q;
	logic [bmfe_pkg::IDX_W-1:0]    final_word_q;
	bmfe_pkg::mode_t               extract_mode_q;
	logic [bmfe_pkg::BITPOS_W-1:0] bit_position_q;
	logic [bmfe_pkg::SCALE_W-1:0]  scale_factor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_terminal_q   <= '0;
			match_subaddress_q <= '0;
			match_direction_q  <= 1'b0;
			first_word_q       <= bmfe_pkg::IDX_W'(1);
			final_word_q       <= bmfe_pkg::IDX_W'(1);
			extract_mode_q     <= bmfe_pkg::MODE_UNSIGNED;
			bit_position_q     <= '0;
			scale_factor_q     <= bmfe_pkg::SCALE_W'(65536);
		end else if (cfg_write) begin
			unique case (bmfe_pkg::reg_idx_t'(cfg_index))
				bmfe_pkg::REG_TERMINAL:   match_terminal_q   <= cfg_data[bmfe_pkg::TERM_W-1:0];
				bmfe_pkg::REG_SUBADDRESS: match_subaddress_q <= cfg_data[bmfe_pkg::SUBADR_W-1:0];
				bmfe_pkg::REG_DIRECTION:  match_direction_q  <= cfg_data[0];
				bmfe_pkg::REG_FIRST_WORD: first_word_q       <= cfg_data[bmfe_pkg::IDX_W-1:0];
				bmfe_pkg::REG_FINAL_WORD: final_word_q       <= cfg_data[bmfe_pkg::IDX_W-1:0];
				bmfe_pkg::REG_MODE:       extract_mode_q     <= bmfe_pkg::mode_t'(cfg_data[1:0]);
				bmfe_pkg::REG_BIT_POS:    bit_position_q     <= cfg_data[bmfe_pkg::BITPOS_W-1:0];
				bmfe_pkg::REG_SCALE:      scale_factor_q     <= cfg_data;
			endcase
		end
	end

	// Pipeline flow control: a stage takes new data when it is empty or
	// when the stage after it is moving.
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic out_ready, rdy_s4, rdy_s3, rdy_s2, rdy_s1;
	logic in_accept;

	assign out_ready = !out_valid_q || !out_stall;
	assign rdy_s4    = !v_s4 || out_ready;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign in_stall  = !rdy_s1;
	assign in_accept = in_valid && !in_stall;

	// Message tracking
	logic [bmfe_pkg::IDX_W-1:0]   word_count_q;
	logic [bmfe_pkg::WORD_W-1:0]  start_word_hold_q;
	logic [bmfe_pkg::VALUE_W-1:0] span_accumulator_q;

	logic [bmfe_pkg::IDX_W-1:0]   count_n;
	logic [bmfe_pkg::WORD_W-1:0]  hold_n;
	logic [bmfe_pkg::VALUE_W-1:0] acc_n;
	logic                         field_ok;

	always_comb begin
		count_n = word_count_q;
		hold_n  = start_word_hold_q;
		acc_n   = span_accumulator_q;
		// Words past the limit are ignored until the message closes.
		if (word_count_q < MaxCount) begin
			count_n = word_count_q + bmfe_pkg::IDX_W'(1);
			if (count_n == first_word_q) begin
				hold_n = data_word;
			end
			if (count_n >= first_word_q && count_n <= final_word_q) begin
				acc_n = {span_accumulator_q[bmfe_pkg::VALUE_W-bmfe_pkg::WORD_W-1:0], data_word};
			end
		end
		field_ok = terminal == match_terminal_q && subaddress == match_subaddress_q &&
			direction == match_direction_q && first_word_q != '0 && final_word_q != '0 &&
			first_word_q <= count_n && final_word_q <= count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q       <= '0;
			start_word_hold_q  <= '0;
			span_accumulator_q <= '0;
		end else if (in_accept) begin
			if (last_word) begin
				word_count_q       <= '0;
				start_word_hold_q  <= '0;
				span_accumulator_q <= '0;
			end else begin
				word_count_q       <= count_n;
				start_word_hold_q  <= hold_n;
				span_accumulator_q <= acc_n;
			end
		end
	end

	// Stage 1: the closed message
	logic [bmfe_pkg::WORD_W-1:0]  hold_s1;
	logic [bmfe_pkg::VALUE_W-1:0] acc_s1;
	logic [bmfe_pkg::STAMP_W-1:0] stamp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_accept && last_word && field_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			hold_s1  <= hold_n;
			acc_s1   <= acc_n;
			stamp_s1 <= time_stamp;
		end
	end

	// Stage 2: decode into a magnitude, a result sign and a scale magnitude.
	// For a float the magnitude operand is the 24-bit significand.
	logic [bmfe_pkg::VALUE_W-1:0] oper_c;
	logic                         neg_c;
	logic                         inf_c;
	logic [7:0]                   exp_c;
	logic [bmfe_pkg::SCALE_W-1:0] scale_mag_c;
	logic                         scale_neg;
	logic [bmfe_pkg::IDX_W-1:0]   span_len;
	logic [bmfe_pkg::VALUE_W-1:0] sext_c;
	logic [31:0]                  raw_flt;

	always_comb begin
		scale_neg   = scale_factor_q[bmfe_pkg::SCALE_W-1];
		scale_mag_c = scale_neg ? (~scale_factor_q + 1'b1) : scale_factor_q;
		span_len    = final_word_q - first_word_q + bmfe_pkg::IDX_W'(1);
		raw_flt     = acc_s1[31:0];
		oper_c      = '0;
		neg_c       = 1'b0;
		inf_c       = 1'b0;
		exp_c       = '0;
		sext_c      = acc_s1;
		case (span_len)
			6'd1:    sext_c = {{48{acc_s1[15]}}, acc_s1[15:0]};
			6'd2:    sext_c = {{32{acc_s1[31]}}, acc_s1[31:0]};
			6'd3:    sext_c = {{16{acc_s1[47]}}, acc_s1[47:0]};
			default: sext_c = acc_s1;
		endcase
		if (extract_mode_q == bmfe_pkg::MODE_BIT) begin
			oper_c = bmfe_pkg::VALUE_W'(hold_s1[bit_position_q]);
			neg_c  = scale_neg;
		end else if (final_word_q < first_word_q) begin
			// Reversed span gives a plain zero.
			oper_c = '0;
			neg_c  = 1'b0;
		end else if (extract_mode_q == bmfe_pkg::MODE_FLOAT && span_len == 6'd2) begin
			neg_c = raw_flt[31] ^ scale_neg;
			inf_c = raw_flt[30:23] == bmfe_pkg::FLT_EXP_SPECIAL;
			if (raw_flt[30:23] == 8'd0) begin
				// Subnormal: exponent acts as one, no hidden bit.
				exp_c  = 8'd1;
				oper_c = {40'd0, 1'b0, raw_flt[22:0]};
			end else begin
				exp_c  = raw_flt[30:23];
				oper_c = {40'd0, 1'b1, raw_flt[22:0]};
			end
		end else if (extract_mode_q == bmfe_pkg::MODE_SIGNED) begin
			neg_c  = sext_c[bmfe_pkg::VALUE_W-1] ^ scale_neg;
			oper_c = sext_c[bmfe_pkg::VALUE_W-1] ? (~sext_c + 1'b1) : sext_c;
		end else begin
			oper_c = acc_s1;
			neg_c  = scale_neg;
		end
	end

	logic [bmfe_pkg::VALUE_W-1:0] oper_s2;
	logic                         neg_s2, inf_s2, flt_s2;
	logic [7:0]                   exp_s2;
	logic [bmfe_pkg::SCALE_W-1:0] scale_s2;
	logic [bmfe_pkg::STAMP_W-1:0] stamp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			oper_s2  <= oper_c;
			neg_s2   <= neg_c;
			inf_s2   <= inf_c;
			flt_s2   <= exp_c != 8'd0;
			exp_s2   <= exp_c;
			scale_s2 <= scale_mag_c;
			stamp_s2 <= stamp_s1;
		end
	end

	// Stage 3: two 32 x 32 partial products
	logic [bmfe_pkg::VALUE_W-1:0] prod_lo_s3, prod_hi_s3;
	logic                         neg_s3, inf_s3, flt_s3;
	logic [7:0]                   exp_s3;
	logic [bmfe_pkg::STAMP_W-1:0] stamp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			prod_lo_s3 <= oper_s2[31:0] * scale_s2;
			prod_hi_s3 <= oper_s2[63:32] * scale_s2;
			neg_s3     <= neg_s2;
			inf_s3     <= inf_s2;
			flt_s3     <= flt_s2;
			exp_s3     <= exp_s2;
			stamp_s3   <= stamp_s2;
		end
	end

	// Stage 4: combine partial products, or place the float product by its
	// exponent with round half away from zero.
	logic [bmfe_pkg::VALUE_W:0]   sum_c;
	logic [bmfe_pkg::VALUE_W-1:0] mag_c;
	logic                         over_c;
	logic signed [8:0]            shift_c;
	logic signed [8:0]            rshift_c;
	logic [127:0]                 wide_c;
	logic [bmfe_pkg::VALUE_W-1:0] trunc_c;

	always_comb begin
		sum_c    = {1'b0, prod_lo_s3} + {1'b0, prod_hi_s3[31:0], 32'd0};
		shift_c  = $signed({1'b0, exp_s3}) - 9'sd150;
		rshift_c = -shift_c;
		wide_c   = {64'd0, prod_lo_s3} << shift_c[5:0];
		trunc_c  = prod_lo_s3 >> (rshift_c[5:0] - 6'd1);
		mag_c    = '0;
		over_c   = 1'b0;
		if (inf_s3) begin
			over_c = 1'b1;
		end else if (flt_s3) begin
			if (shift_c >= 9'sd0) begin
				if (shift_c >= 9'sd63) begin
					over_c = prod_lo_s3 != '0;
				end else begin
					over_c = |wide_c[127:64];
					mag_c  = wide_c[63:0];
				end
			end else if (rshift_c < 9'sd64) begin
				mag_c = {1'b0, trunc_c[63:1]} + {63'd0, trunc_c[0]};
			end
		end else begin
			mag_c  = sum_c[bmfe_pkg::VALUE_W-1:0];
			over_c = (prod_hi_s3[63:32] != '0) || sum_c[bmfe_pkg::VALUE_W];
		end
	end

	logic [bmfe_pkg::VALUE_W-1:0] mag_s4;
	logic                         over_s4, neg_s4;
	logic [bmfe_pkg::STAMP_W-1:0] stamp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			mag_s4   <= mag_c;
			over_s4  <= over_c;
			neg_s4   <= neg_s3;
			stamp_s4 <= stamp_s3;
		end
	end

	// Output register: apply sign and saturate to the signed range.
	logic [bmfe_pkg::VALUE_W-1:0] limit_c;
	logic [bmfe_pkg::VALUE_W-1:0] field_value_q;
	logic [bmfe_pkg::STAMP_W-1:0] value_time_q;
	logic                         saturated_q;

	assign limit_c = neg_s4 ? bmfe_pkg::NEG_LIMIT : bmfe_pkg::POS_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			value_time_q <= stamp_s4;
			if (over_s4 || mag_s4 > limit_c) begin
				field_value_q <= limit_c;
				saturated_q   <= 1'b1;
			end else begin
				field_value_q <= neg_s4 ? (~mag_s4 + 1'b1) : mag_s4;
				saturated_q   <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign field_value = field_value_q;
	assign value_time  = value_time_q;
	assign saturated   = saturated_q;

endmodule
`default_nettype wire

// ----- test/bus_message_field_extractor_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bus_message_field_extractor_tb
// Feeds bus messages word by word into the field extractor under random
// gaps and stalls. A local model of the word tracking and the scaled decode
// predicts every field, and each result transaction is checked in order.
// ---------------------------------------------------------------------------
module bus_message_field_extractor_tb;
	import bmfe_pkg::*;

	localparam int MSG_WORDS    = MAX_WORDS_DEFAULT;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 10;
	localparam int LONG_HOLD    = 300;

	typedef struct packed {
		logic [TERM_W-1:0]   term;
		logic [SUBADR_W-1:0] sub;
		logic                dir;
		logic [WORD_W-1:0]   data;
		logic                last;
		logic [STAMP_W-1:0]  stamp;
	} word_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               sat;
	} scaled_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [STAMP_W-1:0] stamp;
		logic               sat;
	} field_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [TERM_W-1:0] terminal = '0;
	logic [SUBADR_W-1:0] subaddress = '0;
	logic direction = 1'b0;
	logic [WORD_W-1:0] data_word = '0;
	logic last_word = 1'b0;
	logic [STAMP_W-1:0] time_stamp = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [VALUE_W-1:0] field_value;
	logic [STAMP_W-1:0] value_time;
	logic saturated;

	bus_message_field_extractor uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.terminal(terminal),
		.subaddress(subaddress),
		.direction(direction),
		.data_word(data_word),
		.last_word(last_word),
		.time_stamp(time_stamp),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.field_value(field_value),
		.value_time(value_time),
		.saturated(saturated)
	);

	// Local copy of the field configuration.
	logic [TERM_W-1:0]   cfg_term = '0;
	logic [SUBADR_W-1:0] cfg_sub = '0;
	logic                cfg_dir = 1'b0;
	logic [IDX_W-1:0]    cfg_first = 6'd1;
	logic [IDX_W-1:0]    cfg_final = 6'd1;
	mode_t               cfg_mode = MODE_UNSIGNED;
	logic [BITPOS_W-1:0] cfg_bit_pos = '0;
	logic [SCALE_W-1:0]  cfg_scale = 32'h0001_0000;

	// Local copy of the message tracking state.
	int                  msg_word_count = 0;
	logic [WORD_W-1:0]   msg_start_word = '0;
	logic [63:0]         msg_span = '0;

	word_item_t    word_queue[$];
	field_result_t pending_fields[$];
	word_item_t    next_item;
	field_result_t want;
	int words_queued = 0;
	int words_accepted = 0;
	int bad_fields = 0;
	int send_gap = 0;
	int stall_left = 0;
	logic send_idle = 1'b0;
	logic recv_idle = 1'b0;
	logic recv_hold = 1'b0;
	logic hold_armed = 1'b0;

	function automatic scaled_t clip_to_q48(logic over, logic [63:0] mag, logic neg);
		scaled_t res;
		logic [63:0] lim;
		lim = neg ? NEG_LIMIT : POS_LIMIT;
		if (over || mag > lim) begin
			res.value = lim;
			res.sat = 1'b1;
		end else begin
			res.value = neg ? (~mag + 64'd1) : mag;
			res.sat = 1'b0;
		end
		return res;
	endfunction

	// Magnitude times the magnitude of the scale, exact in 96 bits.
	function automatic scaled_t scale_integer(logic [63:0] mag, logic mag_neg);
		logic        scale_neg;
		logic [31:0] scale_mag;
		logic [95:0] prod;
		scale_neg = cfg_scale[31];
		scale_mag = scale_neg ? (~cfg_scale + 32'd1) : cfg_scale;
		prod = {32'd0, mag} * {64'd0, scale_mag};
		return clip_to_q48(|prod[95:64], prod[63:0], mag_neg != scale_neg);
	endfunction

	// Single precision value times the scale, rounded half away from zero.
	function automatic scaled_t scale_single(logic [31:0] raw);
		logic        scale_neg;
		logic        neg;
		logic [31:0] scale_mag;
		logic [7:0]  expo;
		logic [23:0] mant;
		logic [63:0] prod;
		logic [63:0] mag;
		logic        over;
		int          sh;
		int          rsh;
		scale_neg = cfg_scale[31];
		scale_mag = scale_neg ? (~cfg_scale + 32'd1) : cfg_scale;
		neg = raw[31] != scale_neg;
		expo = raw[30:23];
		if (expo == FLT_EXP_SPECIAL)
			return clip_to_q48(1'b1, 64'd0, neg);
		mant = {1'b0, raw[22:0]};
		if (expo == 8'd0)
			expo = 8'd1;
		else
			mant[23] = 1'b1;
		prod = {40'd0, mant} * {32'd0, scale_mag};
		sh = int'(expo) - FLT_EXP_UNIT;
		mag = '0;
		over = 1'b0;
		if (sh >= 0) begin
			if (prod != 64'd0) begin
				if (sh >= 63 || prod > ({64{1'b1}} >> sh))
					over = 1'b1;
				else
					mag = prod << sh;
			end
		end else begin
			rsh = -sh;
			if (rsh < 64)
				mag = (prod >> rsh) + ((prod >> (rsh - 1)) & 64'd1);
		end
		return clip_to_q48(over, mag, neg);
	endfunction

	function automatic scaled_t decode_field();
		scaled_t res;
		logic [63:0] v;
		logic [63:0] mask;
		int span_words;
		if (cfg_mode == MODE_BIT)
			return scale_integer({63'd0, msg_start_word[cfg_bit_pos]}, 1'b0);
		if (cfg_final < cfg_first) begin
			res.value = '0;
			res.sat = 1'b0;
			return res;
		end
		span_words = int'(cfg_final) - int'(cfg_first) + 1;
		if (cfg_mode == MODE_FLOAT && span_words == 2)
			return scale_single(msg_span[31:0]);
		if (cfg_mode == MODE_SIGNED) begin
			v = msg_span;
			// Spans of four words or more use bit 63 of the accumulator as sign.
			if (span_words < 4) begin
				mask = (64'd1 << (span_words * 16)) - 64'd1;
				v = v & mask;
				if (v[span_words * 16 - 1])
					v = v | ~mask;
			end
			if (v[63])
				return scale_integer(~v + 64'd1, 1'b1);
			return scale_integer(v, 1'b0);
		end
		return scale_integer(msg_span, 1'b0);
	endfunction

	// Advances the message state by one accepted word and records the field it closes.
	function automatic void track_word(logic [TERM_W-1:0] t, logic [SUBADR_W-1:0] s, logic d,
			logic [WORD_W-1:0] w, logic last, logic [STAMP_W-1:0] stamp);
		int idx;
		logic hit;
		scaled_t res;
		field_result_t item;
		if (msg_word_count < MSG_WORDS) begin
			idx = msg_word_count + 1;
			msg_word_count = idx;
			if (idx == int'(cfg_first))
				msg_start_word = w;
			if (idx >= int'(cfg_first) && idx <= int'(cfg_final))
				msg_span = {msg_span[47:0], w};
		end
		if (last) begin
			hit = t == cfg_term && s == cfg_sub && d == cfg_dir && cfg_first >= 6'd1 &&
				cfg_final >= 6'd1 && int'(cfg_first) <= msg_word_count &&
				int'(cfg_final) <= msg_word_count;
			if (hit) begin
				res = decode_field();
				item.value = res.value;
				item.stamp = stamp;
				item.sat = res.sat;
				pending_fields = {pending_fields, item};
			end
			msg_word_count = 0;
			msg_start_word = '0;
			msg_span = '0;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [WORD_W-1:0] pick_data_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {1'($urandom), 8'hFF, 7'($urandom)};
			3: return 16'h8000;
			4: return 16'h7FFF;
			5: return {1'($urandom), 8'($urandom_range(100, 200)), 7'($urandom)};
			6: return {1'($urandom), 8'h00, 7'($urandom)};
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly lengths that reach the field, some short, some past the word limit.
	function automatic int pick_len();
		int reach;
		int r;
		reach = (cfg_final > cfg_first) ? int'(cfg_final) : int'(cfg_first);
		if (reach < 1)
			reach = 1;
		if (reach > MSG_WORDS)
			reach = MSG_WORDS;
		r = $urandom_range(0, 99);
		if (r < 55)
			return reach + $urandom_range(0, 2);
		if (r < 75)
			return $urandom_range(1, 8);
		if (r < 90)
			return (reach > 1) ? reach - 1 : 1;
		if (r < 97)
			return $urandom_range(9, MSG_WORDS);
		return $urandom_range(MSG_WORDS + 1, MSG_WORDS + 8);
	endfunction

	task automatic queue_word(logic [TERM_W-1:0] t, logic [SUBADR_W-1:0] s, logic d,
			logic [WORD_W-1:0] w, logic last);
		word_item_t item;
		item.term = t;
		item.sub = s;
		item.dir = d;
		item.data = w;
		item.last = last;
		item.stamp = {$urandom, $urandom};
		word_queue = {word_queue, item};
		words_queued++;
	endtask

	task automatic queue_pair(logic [WORD_W-1:0] hi, logic [WORD_W-1:0] lo);
		queue_word(cfg_term, cfg_sub, cfg_dir, hi, 1'b0);
		queue_word(cfg_term, cfg_sub, cfg_dir, lo, 1'b1);
	endtask

	task automatic queue_message(int len);
		logic [TERM_W-1:0] t;
		logic [SUBADR_W-1:0] s;
		logic d;
		t = cfg_term;
		s = cfg_sub;
		d = cfg_dir;
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 3))
				0: t = 5'($urandom);
				1: s = 5'($urandom);
				2: d = ~d;
				default: begin
					t = 5'($urandom);
					s = 5'($urandom);
					d = 1'($urandom);
				end
			endcase
		end
		// The key only counts on the closing word, so earlier words carry noise.
		for (int i = 0; i < len - 1; i++)
			queue_word(5'($urandom), 5'($urandom), 1'($urandom), pick_data_word(), 1'b0);
		queue_word(t, s, d, pick_data_word(), 1'b1);
	endtask

	task automatic random_traffic(int n_words);
		int sent;
		int len;
		sent = 0;
		send_idle <= ($urandom_range(0, 2) != 0);
		recv_idle <= ($urandom_range(0, 2) != 0);
		while (sent < n_words) begin
			len = pick_len();
			queue_message(len);
			sent += len;
		end
	endtask

	task automatic wait_idle();
		while (words_accepted != words_queued || pending_fields.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_TERMINAL:   cfg_term = val[TERM_W-1:0];
			REG_SUBADDRESS: cfg_sub = val[SUBADR_W-1:0];
			REG_DIRECTION:  cfg_dir = val[0];
			REG_FIRST_WORD: cfg_first = val[IDX_W-1:0];
			REG_FINAL_WORD: cfg_final = val[IDX_W-1:0];
			REG_MODE:       cfg_mode = mode_t'(val[1:0]);
			REG_BIT_POS:    cfg_bit_pos = val[BITPOS_W-1:0];
			REG_SCALE:      cfg_scale = val;
			default: ;
		endcase
	endtask

	task automatic configure(logic [TERM_W-1:0] t, logic [SUBADR_W-1:0] s, logic d,
			logic [IDX_W-1:0] first, logic [IDX_W-1:0] final_idx, mode_t m,
			logic [BITPOS_W-1:0] bpos, logic [SCALE_W-1:0] scale);
		wait_idle();
		write_reg(REG_TERMINAL, {27'd0, t});
		write_reg(REG_SUBADDRESS, {27'd0, s});
		write_reg(REG_DIRECTION, {31'd0, d});
		write_reg(REG_FIRST_WORD, {26'd0, first});
		write_reg(REG_FINAL_WORD, {26'd0, final_idx});
		write_reg(REG_MODE, {30'd0, m});
		write_reg(REG_BIT_POS, {28'd0, bpos});
		write_reg(REG_SCALE, scale);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Word driver: one transaction per accepted word, gaps drawn after each word.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				track_word(terminal, subaddress, direction, data_word, last_word, time_stamp);
				words_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (word_queue.size() != 0) begin
					next_item = word_queue.pop_front();
					in_valid <= 1'b1;
					terminal <= next_item.term;
					subaddress <= next_item.sub;
					direction <= next_item.dir;
					data_word <= next_item.data;
					last_word <= next_item.last;
					time_stamp <= next_item.stamp;
					send_gap = send_idle ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall generator.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_fields.size() == 0) begin
					if (bad_fields < 10)
						$display("%0t: unexpected field value %h time %h sat %b",
							$realtime, field_value, value_time, saturated);
					bad_fields++;
				end else begin
					want = pending_fields.pop_front();
					if (field_value !== want.value || value_time !== want.stamp ||
							saturated !== want.sat) begin
						if (bad_fields < 10)
							$display("%0t: field error: value %h/%h time %h/%h sat %b/%b",
								$realtime, want.value, field_value, want.stamp,
								value_time, want.sat, saturated);
						bad_fields++;
					end
				end
			end
			if (stall_left > 0)
				stall_left--;
			else if (recv_idle && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			out_stall <= recv_hold || stall_left > 0;
		end
	end

	// Long receiver hold-off so that finished fields back up into the input.
	initial begin
		@(posedge hold_armed);
		recv_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		recv_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("bus_message_field_extractor: mismatch");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: key 0/0/receive, word 1 unsigned, unit scale.
		queue_word(5'd0, 5'd0, 1'b0, 16'hFFFF, 1'b1);
		queue_word(5'd0, 5'd0, 1'b0, 16'h0000, 1'b1);
		queue_word(5'd1, 5'd0, 1'b0, 16'h1234, 1'b1);
		queue_word(5'd0, 5'd1, 1'b0, 16'h1234, 1'b1);
		queue_word(5'd0, 5'd0, 1'b1, 16'h1234, 1'b1);
		queue_word(5'd31, 5'd31, 1'b1, 16'hABCD, 1'b1);

		configure(5'd31, 5'd31, 1'b1, 6'd3, 6'd3, MODE_BIT, 4'd15, 32'h7FFF_FFFF);
		queue_word(5'd0, 5'd0, 1'b0, 16'h1234, 1'b0);
		queue_word(5'd5, 5'd5, 1'b0, 16'h0000, 1'b0);
		queue_word(5'd31, 5'd31, 1'b1, 16'h8000, 1'b1);

		// Not-a-number, negative infinity, smallest subnormal, largest finite, 1.5.
		configure(5'd7, 5'd12, 1'b0, 6'd1, 6'd2, MODE_FLOAT, 4'd0, 32'h0001_0000);
		queue_pair(16'h7FC0, 16'h0001);
		queue_pair(16'hFF80, 16'h0000);
		queue_pair(16'h0000, 16'h0001);
		queue_pair(16'h7F7F, 16'hFFFF);
		queue_pair(16'h3FC0, 16'h0000);

		configure(5'd3, 5'd30, 1'b1, 6'd1, 6'd1, MODE_SIGNED, 4'd0, 32'h8000_0000);
		queue_word(5'd3, 5'd30, 1'b1, 16'h8000, 1'b1);
		queue_word(5'd3, 5'd30, 1'b1, 16'h7FFF, 1'b1);

		// Final word before first word yields zero outside single bit mode.
		configure(5'd9, 5'd9, 1'b0, 6'd5, 6'd2, MODE_UNSIGNED, 4'd0, 32'h0001_0000);
		for (int i = 0; i < 4; i++)
			queue_word(5'd9, 5'd9, 1'b0, 16'($urandom), 1'b0);
		queue_word(5'd9, 5'd9, 1'b0, 16'($urandom), 1'b1);

		configure(5'($urandom), 5'($urandom), 1'($urandom), 6'd1, 6'd4, MODE_SIGNED, 4'd0,
			32'h8000_0000);
		random_traffic(35);
		configure(5'($urandom), 5'($urandom), 1'($urandom), 6'd2, 6'd3, MODE_FLOAT, 4'd7,
			32'h0001_0000);
		random_traffic(35);
		configure(5'($urandom), 5'($urandom), 1'($urandom), 6'd1, 6'd2, MODE_FLOAT, 4'd3,
			32'hFFFF_0000);
		random_traffic(35);
		configure(5'($urandom), 5'($urandom), 1'($urandom), 6'd1, 6'd6, MODE_SIGNED, 4'd0,
			32'h0000_0001);
		random_traffic(35);
		configure(5'($urandom), 5'($urandom), 1'($urandom), 6'd2, 6'd7, MODE_UNSIGNED, 4'd0,
			32'h7FFF_FFFF);
		random_traffic(35);
		configure(5'($urandom), 5'($urandom), 1'($urandom), 6'd4, 6'd1, MODE_BIT, 4'd0,
			32'hFFFF_FFFF);
		random_traffic(35);
		configure(5'($urandom), 5'($urandom), 1'($urandom), 6'd0, 6'd3, MODE_UNSIGNED, 4'd0,
			32'h0001_0000);
		random_traffic(15);
		configure(5'($urandom), 5'($urandom), 1'($urandom), 6'd2, 6'd40, MODE_UNSIGNED, 4'd0,
			32'h0001_0000);
		random_traffic(15);
		configure(5'($urandom), 5'($urandom), 1'($urandom), 6'd32, 6'd32, MODE_UNSIGNED,
			4'd0, 32'h0000_0000);
		random_traffic(60);

		// Back-to-back single word messages that each close a field while
		// the receiver holds off.
		configure(5'($urandom), 5'($urandom), 1'($urandom), 6'd1, 6'd1, MODE_UNSIGNED, 4'd0,
			32'($urandom));
		send_idle <= 1'b0;
		recv_idle <= 1'b0;
		hold_armed <= 1'b1;
		for (int i = 0; i < 120; i++)
			queue_word(cfg_term, cfg_sub, cfg_dir, pick_data_word(), 1'b1);

		for (int p = 0; p < 4; p++) begin
			configure(5'($urandom), 5'($urandom), 1'($urandom), 6'($urandom_range(1, 8)),
				6'($urandom_range(1, 8)), mode_t'($urandom_range(0, 3)),
				4'($urandom), 32'($urandom));
			random_traffic(35);
		end

		wait_idle();
		if (bad_fields == 0 && pending_fields.size() == 0)
			$display("bus_message_field_extractor: match");
		else
			$display("bus_message_field_extractor: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/bmfe_pkg.sv
rtl/bus_message_field_extractor.sv
test/bus_message_field_extractor_tb.sv
